@@ src/csvt_pkg.sv @@
// Package: item types, character codes and event kinds of the CSV tokenizer.
package csvt_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_COMMA     = 8'h2C;

    localparam logic       REQ_DATA  = 1'b0;
    localparam logic       REQ_FLUSH = 1'b1;

    localparam logic [1:0] EV_CONTENT   = 2'd0;
    localparam logic [1:0] EV_FIELD_END = 2'd1;
    localparam logic [1:0] EV_ROW_END   = 2'd2;

    localparam int MAX_RES = 3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] out_byte;
        logic       last;
    } t_out;

    // one result before the last flag is known
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } t_res;

    // all results caused by one input item
    typedef struct packed {
        logic [1:0]             cnt;
        t_res [MAX_RES-1:0]     res;
    } t_work;

endpackage

@@ src/csvt_front.sv @@
// Front end: decodes escapes, tracks quote/field/row flags, builds result lists.
module csvt_front
    import csvt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_in   i_item,
    output logic  o_push,
    output t_work o_work
);

    logic r_esc, r_quote, r_field, r_row;
    logic n_esc, n_quote, n_field, n_row;

    always_comb begin
        t_work      w;
        logic [1:0] k;
        logic       do_plain;
        logic [7:0] c;

        w        = '0;
        k        = 2'd0;
        do_plain = 1'b0;
        c        = i_item.in_byte;
        n_esc    = r_esc;
        n_quote  = r_quote;
        n_field  = r_field;
        n_row    = r_row;

        if (i_item.req_type == REQ_FLUSH) begin
            if (r_esc) begin
                w.res[k] = '{kind: EV_CONTENT, data: CH_BACKSLASH};
                k        = k + 2'd1;
                n_field  = 1'b1;
                n_row    = 1'b1;
            end
            if (n_row) begin
                if (n_field) begin
                    w.res[k] = '{kind: EV_FIELD_END, data: 8'h00};
                    k        = k + 2'd1;
                end
                w.res[k] = '{kind: EV_ROW_END, data: 8'h00};
                k        = k + 2'd1;
            end
            n_esc   = 1'b0;
            n_quote = 1'b0;
            n_field = 1'b0;
            n_row   = 1'b0;
        end else if (r_esc) begin
            n_esc   = 1'b0;
            n_field = 1'b1;
            n_row   = 1'b1;
            if (c == CH_LOWER_N) begin
                w.res[k] = '{kind: EV_CONTENT, data: CH_LF};
                k        = k + 2'd1;
            end else if (c == CH_LOWER_T) begin
                w.res[k] = '{kind: EV_CONTENT, data: CH_TAB};
                k        = k + 2'd1;
            end else begin
                w.res[k] = '{kind: EV_CONTENT, data: CH_BACKSLASH};
                k        = k + 2'd1;
                do_plain = 1'b1;
            end
        end else begin
            do_plain = 1'b1;
        end

        if (do_plain) begin
            if (c == CH_BACKSLASH) begin
                n_esc = 1'b1;
            end else if (c == CH_CR) begin
                n_esc = n_esc;   // carriage return dropped
            end else if (c == CH_LF) begin
                if (n_field) begin
                    w.res[k] = '{kind: EV_FIELD_END, data: 8'h00};
                    k        = k + 2'd1;
                end
                w.res[k] = '{kind: EV_ROW_END, data: 8'h00};
                k        = k + 2'd1;
                n_quote  = 1'b0;
                n_field  = 1'b0;
                n_row    = 1'b0;
            end else begin
                n_row = 1'b1;
                if (c == CH_QUOTE) begin
                    n_quote = ~n_quote;
                end else if (c == CH_COMMA && !n_quote) begin
                    w.res[k] = '{kind: EV_FIELD_END, data: 8'h00};
                    k        = k + 2'd1;
                    n_field  = 1'b0;
                end else begin
                    w.res[k] = '{kind: EV_CONTENT, data: c};
                    k        = k + 2'd1;
                    n_field  = 1'b1;
                end
            end
        end

        w.cnt  = k;
        o_work = w;
        o_push = i_accept && (k != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= 1'b0;
            r_quote <= 1'b0;
            r_field <= 1'b0;
            r_row   <= 1'b0;
        end else if (i_accept) begin
            r_esc   <= n_esc;
            r_quote <= n_quote;
            r_field <= n_field;
            r_row   <= n_row;
        end
    end

endmodule

@@ src/csvt_queue.sv @@
// Small register FIFO of result lists between front and back end.
module csvt_queue
    import csvt_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_wdata,
    input  logic  i_pop,
    output t_work o_rdata,
    output logic  o_empty,
    output logic  o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_work           r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_cnt;
    logic [PW-1:0]   n_wptr, n_rptr;
    logic [CW-1:0]   n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_rdata = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

@@ src/csvt_back.sv @@
// Back end: walks one result list at a time and sends one result per cycle while the receiver is ready.
module csvt_back
    import csvt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_empty,
    input  t_work i_head,
    output logic  o_pop,
    output logic  o_valid,
    input  logic  i_ready,
    output t_out  o_data
);

    t_work      r_work;
    logic [1:0] r_idx;
    logic       r_busy;
    logic [1:0] n_idx;
    logic       n_busy;
    logic       take, at_end, done;

    assign o_valid = r_busy;
    assign take    = r_busy && i_ready;
    assign at_end  = (r_idx == r_work.cnt - 2'd1);
    assign done    = !r_busy || (take && at_end);
    assign o_pop   = done && !i_empty;

    assign o_data.event_kind = r_work.res[r_idx].kind;
    assign o_data.out_byte   = r_work.res[r_idx].data;
    assign o_data.last       = at_end;

    always_comb begin
        n_idx  = r_idx;
        n_busy = r_busy;
        if (o_pop) begin
            n_idx  = 2'd0;
            n_busy = 1'b1;
        end else if (done) begin
            n_busy = 1'b0;
        end else if (take) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= 2'd0;
            r_busy <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_busy <= n_busy;
        end
    end

endmodule

@@ src/csv_tokenizer_with_escapes.sv @@
// Top level: CSV tokenizer with backslash escapes, valid/ready in and out.
//
// Input channel (i_valid/o_ready, i_data): one item per byte of text, or a
// flush item (req_type = 1) at end of input. Output channel (o_valid/i_ready,
// o_data): field content bytes, field-end and row-end events, with last set
// on the final result caused by an input item. An item that causes no
// result (CR, quote, first backslash, empty flush) produces nothing.
//
// The front end decodes escapes and updates the quote/field/row flags in
// the cycle the item is accepted, so an item is taken every cycle while the
// FIFO has room. A non-empty result list (1 to 3 results) goes into a FIFO
// of QUEUE_DEPTH entries. The back end pops one list and presents one
// result per cycle from registers while the receiver is ready. Throughput
// is one input item per cycle for items with one result; the output port,
// one result per cycle, sets the rate otherwise.
//
// Reset clears the flags, FIFO pointers and back end. When the receiver
// stalls, the current result holds, the FIFO fills and o_ready drops.
module csv_tokenizer_with_escapes
    import csvt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic  accept;
    logic  push, pop, q_empty, q_full;
    t_work front_work, head_work;

    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    csvt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_data),
        .o_push   (push),
        .o_work   (front_work)
    );

    csvt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_work),
        .i_pop   (pop),
        .o_rdata (head_work),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    csvt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (head_work),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
